/* design/pfcs_pkg.sv */
// Shared types, format codes and range helpers for the pixel format converter.
package pfcs_pkg;

    typedef logic [2:0] fmt_t;

    localparam fmt_t FMT_BIT    = 3'd0;
    localparam fmt_t FMT_UBYTE  = 3'd1;
    localparam fmt_t FMT_SBYTE  = 3'd2;
    localparam fmt_t FMT_SHORT  = 3'd3;
    localparam fmt_t FMT_LONG   = 3'd4;
    localparam fmt_t FMT_SINGLE = 3'd5;
    localparam fmt_t FMT_DOUBLE = 3'd6;

    typedef logic signed [12:0] exp_t;

    // value = mant * 2^expo (unpacked), or 1.mant[62:0] * 2^expo (normalized)
    typedef struct packed {
        logic        bypass;
        logic [63:0] raw_out;
        fmt_t        tf;
        logic        sign;
        logic        is_nan;
        logic        is_inf;
        logic        is_zero;
        logic [63:0] mant;
        exp_t        expo;
    } num_t;

    typedef struct packed {
        logic        bypass;
        logic [63:0] raw_out;
        fmt_t        tf;
        logic        sign;
        logic        is_nan;
        logic        is_inf;
        logic        is_zero;
        logic        big;
        logic [63:0] mant;
        exp_t        expo;
        logic [31:0] quo;
        logic        rnd;
        logic        sticky;
    } aln_t;

    function automatic logic [63:0] fmt_mask(input fmt_t f);
        case (f)
            FMT_SHORT:              fmt_mask = 64'h0000_0000_0000_FFFF;
            FMT_LONG, FMT_SINGLE:   fmt_mask = 64'h0000_0000_FFFF_FFFF;
            FMT_DOUBLE:             fmt_mask = 64'hFFFF_FFFF_FFFF_FFFF;
            default:                fmt_mask = 64'h0000_0000_0000_00FF;
        endcase
    endfunction

    function automatic logic [31:0] int_hi(input fmt_t f);
        case (f)
            FMT_BIT:   int_hi = 32'd1;
            FMT_UBYTE: int_hi = 32'd255;
            FMT_SBYTE: int_hi = 32'd127;
            FMT_SHORT: int_hi = 32'd32767;
            default:   int_hi = 32'h7FFF_FFFF;
        endcase
    endfunction

    // magnitude of the lower limit
    function automatic logic [31:0] int_lomag(input fmt_t f);
        case (f)
            FMT_SBYTE: int_lomag = 32'd128;
            FMT_SHORT: int_lomag = 32'd32768;
            FMT_LONG:  int_lomag = 32'h8000_0000;
            default:   int_lomag = 32'd0;
        endcase
    endfunction

endpackage

/* design/pixel_format_convert_saturate.sv */
// Pixel format converter with saturation: config registers and four-stage pipeline.
// Stages, in order from input transaction to result: unpack, normalize, align, pack.
// Throughput: one pixel per cycle while the output is not stalled; every stage is a register with its own valid bit.
// A stall at the output backs up stage by stage; nothing is dropped or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and clears both format registers.
module pixel_format_convert_saturate (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_pixel_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_pixel_out,
    output logic        m_clipped,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    pfcs_pkg::fmt_t src_fmt_reg;
    pfcs_pkg::fmt_t tgt_fmt_reg;

    logic           v1;
    logic           r1;
    pfcs_pkg::num_t d1;
    logic           v2;
    logic           r2;
    pfcs_pkg::num_t d2;
    logic           v3;
    logic           r3;
    pfcs_pkg::aln_t d3;

    assign pready = 1'b1;
    assign prdata = {29'd0, (paddr[2] ? tgt_fmt_reg : src_fmt_reg)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_fmt_reg <= pfcs_pkg::FMT_BIT;
            tgt_fmt_reg <= pfcs_pkg::FMT_BIT;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) begin
                tgt_fmt_reg <= pwdata[2:0];
            end else begin
                src_fmt_reg <= pwdata[2:0];
            end
        end
    end

    pfcs_unpack u_unpack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .src_fmt   (src_fmt_reg),
        .tgt_fmt   (tgt_fmt_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .pixel_in  (s_pixel_in),
        .out_valid (v1),
        .out_ready (r1),
        .out_data  (d1)
    );

    pfcs_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1),
        .in_ready  (r1),
        .in_data   (d1),
        .out_valid (v2),
        .out_ready (r2),
        .out_data  (d2)
    );

    pfcs_align u_align (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v2),
        .in_ready  (r2),
        .in_data   (d2),
        .out_valid (v3),
        .out_ready (r3),
        .out_data  (d3)
    );

    pfcs_pack u_pack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v3),
        .in_ready  (r3),
        .in_data   (d3),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .pixel_out (m_pixel_out),
        .clipped   (m_clipped)
    );

    // backpressure only ever comes from a full, stalled output
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a stalled output");

    a_clip_int_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_clipped) |-> (tgt_fmt_reg <= pfcs_pkg::FMT_LONG))
        else $error("clipped raised for a float target");

    a_bad_code_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && ((src_fmt_reg > pfcs_pkg::FMT_DOUBLE) ||
                     (tgt_fmt_reg > pfcs_pkg::FMT_DOUBLE)))
        |-> ((m_pixel_out == 64'd0) && !m_clipped))
        else $error("unused format code gave a nonzero result");

    a_bit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (tgt_fmt_reg == pfcs_pkg::FMT_BIT) && (src_fmt_reg != pfcs_pkg::FMT_BIT))
        |-> (m_pixel_out[63:1] == 63'd0))
        else $error("bit target out of range");

endmodule

/* design/pfcs_unpack.sv */
// Stage 1: decode the source pixel into sign, integer mantissa and exponent.
module pfcs_unpack (
    input  logic                aclk,
    input  logic                aresetn,
    input  pfcs_pkg::fmt_t      src_fmt,
    input  pfcs_pkg::fmt_t      tgt_fmt,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [63:0]         pixel_in,
    output logic                out_valid,
    input  logic                out_ready,
    output pfcs_pkg::num_t      out_data
);

    logic           valid_reg;
    pfcs_pkg::num_t data_reg;
    pfcs_pkg::num_t data_next;

    logic [31:0] ival;
    logic [31:0] imag;
    logic [7:0]  se;
    logic [22:0] sfr;
    logic [10:0] de;
    logic [51:0] dfr;
    logic        invalid;

    always_comb begin
        case (src_fmt)
            pfcs_pkg::FMT_SBYTE: ival = {{24{pixel_in[7]}}, pixel_in[7:0]};
            pfcs_pkg::FMT_SHORT: ival = {{16{pixel_in[15]}}, pixel_in[15:0]};
            pfcs_pkg::FMT_LONG:  ival = pixel_in[31:0];
            default:             ival = {24'd0, pixel_in[7:0]};
        endcase
        imag = ival[31] ? (~ival + 32'd1) : ival;
        se   = pixel_in[30:23];
        sfr  = pixel_in[22:0];
        de   = pixel_in[62:52];
        dfr  = pixel_in[51:0];

        invalid = (src_fmt > pfcs_pkg::FMT_DOUBLE) || (tgt_fmt > pfcs_pkg::FMT_DOUBLE);

        data_next.bypass  = invalid || (src_fmt == tgt_fmt);
        data_next.raw_out = invalid ? 64'd0 : (pixel_in & pfcs_pkg::fmt_mask(src_fmt));
        data_next.tf      = tgt_fmt;
        data_next.sign    = ival[31];
        data_next.is_nan  = 1'b0;
        data_next.is_inf  = 1'b0;
        data_next.is_zero = (imag == 32'd0);
        data_next.mant    = {32'd0, imag};
        data_next.expo    = '0;

        case (src_fmt)
            pfcs_pkg::FMT_SINGLE: begin
                data_next.sign    = pixel_in[31];
                data_next.is_nan  = (se == 8'hFF) && (sfr != 23'd0);
                data_next.is_inf  = (se == 8'hFF) && (sfr == 23'd0);
                data_next.is_zero = (se == 8'd0) && (sfr == 23'd0);
                data_next.mant    = {40'd0, (se != 8'd0), sfr};
                data_next.expo    = (se != 8'd0) ?
                                    (pfcs_pkg::exp_t'({5'd0, se}) - 13'sd150) : -13'sd149;
            end
            pfcs_pkg::FMT_DOUBLE: begin
                data_next.sign    = pixel_in[63];
                data_next.is_nan  = (de == 11'h7FF) && (dfr != 52'd0);
                data_next.is_inf  = (de == 11'h7FF) && (dfr == 52'd0);
                data_next.is_zero = (de == 11'd0) && (dfr == 52'd0);
                data_next.mant    = {11'd0, (de != 11'd0), dfr};
                data_next.expo    = (de != 11'd0) ?
                                    (pfcs_pkg::exp_t'({2'd0, de}) - 13'sd1075) : -13'sd1074;
            end
            default: begin
            end
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

/* design/pfcs_norm.sv */
// Stage 2: normalize a nonzero mantissa so its top bit is set and fix up the exponent.
module pfcs_norm (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  pfcs_pkg::num_t      in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pfcs_pkg::num_t      out_data
);

    logic           valid_reg;
    pfcs_pkg::num_t data_reg;
    pfcs_pkg::num_t data_next;

    logic [63:0] m;
    logic [5:0]  lz;

    always_comb begin
        m  = in_data.mant;
        lz = '0;
        if (m[63:32] == 32'd0) begin
            m     = {m[31:0], 32'd0};
            lz[5] = 1'b1;
        end
        if (m[63:48] == 16'd0) begin
            m     = {m[47:0], 16'd0};
            lz[4] = 1'b1;
        end
        if (m[63:56] == 8'd0) begin
            m     = {m[55:0], 8'd0};
            lz[3] = 1'b1;
        end
        if (m[63:60] == 4'd0) begin
            m     = {m[59:0], 4'd0};
            lz[2] = 1'b1;
        end
        if (m[63:62] == 2'd0) begin
            m     = {m[61:0], 2'd0};
            lz[1] = 1'b1;
        end
        if (!m[63]) begin
            m     = {m[62:0], 1'b0};
            lz[0] = 1'b1;
        end
        data_next      = in_data;
        data_next.mant = m;
        data_next.expo = in_data.expo + 13'sd63 - pfcs_pkg::exp_t'({7'd0, lz});
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

/* design/pfcs_align.sv */
// Stage 3: shift the mantissa to the target's binary point, keeping round and sticky bits.
module pfcs_align (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  pfcs_pkg::num_t      in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pfcs_pkg::aln_t      out_data
);

    logic           valid_reg;
    pfcs_pkg::aln_t data_reg;
    pfcs_pkg::aln_t data_next;

    pfcs_pkg::exp_t rsw;
    logic [6:0]     rs;
    logic [127:0]   sh;

    always_comb begin
        rsw = '0;
        if (in_data.tf == pfcs_pkg::FMT_SINGLE) begin
            if (in_data.expo >= -13'sd126) begin
                rsw = 13'sd40;
            end else if (in_data.expo < -13'sd213) begin
                rsw = 13'sd127;
            end else begin
                rsw = -13'sd86 - in_data.expo;
            end
        end else begin
            // integer targets (a double target does not use quo); at or above 2^32 an integer value saturates anyway
            if (in_data.expo < -13'sd64) begin
                rsw = 13'sd127;
            end else if (in_data.expo < 13'sd32) begin
                rsw = 13'sd63 - in_data.expo;
            end
        end
        rs = rsw[6:0];
        sh = {in_data.mant, 64'd0} >> rs;

        data_next.bypass  = in_data.bypass;
        data_next.raw_out = in_data.raw_out;
        data_next.tf      = in_data.tf;
        data_next.sign    = in_data.sign;
        data_next.is_nan  = in_data.is_nan;
        data_next.is_inf  = in_data.is_inf;
        data_next.is_zero = in_data.is_zero;
        data_next.big     = in_data.is_inf || (!in_data.is_zero && (in_data.expo >= 13'sd32));
        data_next.mant    = in_data.mant;
        data_next.expo    = in_data.expo;
        data_next.quo     = sh[95:64];
        data_next.rnd     = sh[63];
        data_next.sticky  = |sh[62:0];
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

/* design/pfcs_pack.sv */
// Stage 4: round, clamp and pack the result into the target format; output register.
module pfcs_pack (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  pfcs_pkg::aln_t      in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [63:0]         pixel_out,
    output logic                clipped
);

    logic        valid_reg;
    logic [63:0] pixel_reg;
    logic [63:0] pixel_next;
    logic        clip_reg;
    logic        clip_next;

    logic [31:0]    hi;
    logic [31:0]    lom;
    logic           fnz;
    logic           over;
    logic           inc;
    logic [32:0]    mag;
    logic [32:0]    sv;
    logic [24:0]    sum;
    logic [7:0]     ebase;
    logic [30:0]    tot;
    pfcs_pkg::exp_t et;
    pfcs_pkg::exp_t ed;

    always_comb begin
        hi    = pfcs_pkg::int_hi(in_data.tf);
        lom   = pfcs_pkg::int_lomag(in_data.tf);
        fnz   = in_data.rnd || in_data.sticky;
        if (in_data.sign) begin
            over = in_data.big || (in_data.quo > lom) || ((in_data.quo == lom) && fnz);
        end else begin
            over = in_data.big || (in_data.quo > hi) || ((in_data.quo == hi) && fnz);
        end
        inc   = in_data.rnd && (in_data.sticky || in_data.quo[0]);
        if (over) begin
            mag = {1'b0, (in_data.sign ? lom : hi)};
        end else if (in_data.tf == pfcs_pkg::FMT_LONG) begin
            mag = {1'b0, in_data.quo};
        end else begin
            mag = {1'b0, in_data.quo} + {32'd0, inc};
        end
        sv    = in_data.sign ? (~mag + 33'd1) : mag;

        // normal results carry the hidden bit in sum[23], which adds one to ebase
        sum   = {1'b0, in_data.quo[23:0]} + {24'd0, inc};
        et    = in_data.expo + 13'sd126;
        ebase = (in_data.expo >= -13'sd126) ? et[7:0] : 8'd0;
        tot   = {ebase, 23'd0} + {6'd0, sum};
        ed    = in_data.expo + 13'sd1023;

        pixel_next = 64'd0;
        clip_next  = 1'b0;
        if (in_data.bypass) begin
            pixel_next = in_data.raw_out;
        end else if (!in_data.is_nan) begin
            case (in_data.tf)
                pfcs_pkg::FMT_SINGLE: begin
                    if (in_data.is_zero) begin
                        pixel_next = {32'd0, in_data.sign, 31'd0};
                    end else if (in_data.is_inf || (in_data.expo > 13'sd127)) begin
                        pixel_next = {32'd0, in_data.sign, 8'hFF, 23'd0};
                    end else begin
                        pixel_next = {32'd0, in_data.sign, tot};
                    end
                end
                pfcs_pkg::FMT_DOUBLE: begin
                    if (in_data.is_zero) begin
                        pixel_next = {in_data.sign, 63'd0};
                    end else if (in_data.is_inf) begin
                        pixel_next = {in_data.sign, 11'h7FF, 52'd0};
                    end else begin
                        pixel_next = {in_data.sign, ed[10:0], in_data.mant[62:11]};
                    end
                end
                default: begin
                    pixel_next = {32'd0, sv[31:0]} & pfcs_pkg::fmt_mask(in_data.tf);
                    clip_next  = over;
                end
            endcase
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign pixel_out = pixel_reg;
    assign clipped   = clip_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            pixel_reg <= pixel_next;
            clip_reg  <= clip_next;
        end
    end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the pixel format converter: directed table plus random traffic.
`timescale 1ns / 100ps

module testbench;

    localparam logic [2:0] ADDR_SRC = 3'd0;
    localparam logic [2:0] ADDR_DST = 3'd4;
    localparam pfcs_pkg::fmt_t FMT_NONE = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 700;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_pixel_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_pixel_out;
    logic        m_clipped;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    pixel_format_convert_saturate dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    typedef struct {
        pfcs_pkg::fmt_t sf;
        pfcs_pkg::fmt_t tf;
        logic [63:0]    pix;
        bit             known;
        logic [63:0]    want_pix;
        logic           want_clip;
    } vec_t;

    logic [63:0]    want_pix_q[$];
    logic           want_clip_q[$];
    int             mismatches = 0;
    int             cycles = 0;
    bit             long_hold = 0;
    pfcs_pkg::fmt_t cur_sf = pfcs_pkg::FMT_BIT;
    pfcs_pkg::fmt_t cur_tf = pfcs_pkg::FMT_BIT;

    // binary32 -> binary64 bits, exact (denormals normalized)
    function automatic logic [63:0] widen_single(logic [31:0] b);
        logic [23:0] m;
        int          e;
        m = {1'b0, b[22:0]};
        if (b[30:23] == 8'hFF)
            return {b[31], 11'h7FF, b[22:0], 29'd0};
        if (b[30:0] == 0)
            return {b[31], 63'd0};
        if (b[30:23] == 0) begin
            e = -126;
            while (!m[23]) begin
                m = m << 1;
                e--;
            end
            return {b[31], 11'(e + 1023), m[22:0], 29'd0};
        end
        return {b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'd0};
    endfunction

    // binary64 -> binary32 bits, nearest-even; overflow gives infinity
    function automatic logic [31:0] narrow_double(logic [63:0] b);
        logic [63:0] sig, kept, rem, half;
        int          ue, sh;
        if (b[62:52] == 11'h7FF)
            return {b[31 + 32], 8'hFF, (b[51:0] != 0) ? 23'h400000 : 23'd0};
        if (b[62:52] == 0)
            return {b[63], 31'd0};
        ue = int'(b[62:52]) - 1023;
        sig = {11'd0, 1'b1, b[51:0]};
        sh = (ue >= -126) ? 29 : 29 + (-126 - ue);
        if (sh > 62) sh = 62;
        kept = sig >> sh;
        rem = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0])) kept++;
        if (ue >= -126) begin
            if (kept[24]) begin
                kept = kept >> 1;
                ue++;
            end
            if (ue > 127) return {b[63], 8'hFF, 23'd0};
            return {b[63], 8'(ue + 127), kept[22:0]};
        end
        return {b[63], kept[30:0]};
    endfunction

    function automatic longint round_even(real d);
        longint t;
        real    f;
        t = $rtoi(d);
        f = d - t;
        if (f > 0.5 || (f == 0.5 && t[0])) t++;
        else if (f < -0.5 || (f == -0.5 && t[0])) t--;
        return t;
    endfunction

    function automatic void int_range(pfcs_pkg::fmt_t f, output longint lo, output longint hi);
        case (f)
            pfcs_pkg::FMT_BIT:   begin lo = 0;      hi = 1;     end
            pfcs_pkg::FMT_UBYTE: begin lo = 0;      hi = 255;   end
            pfcs_pkg::FMT_SBYTE: begin lo = -128;   hi = 127;   end
            pfcs_pkg::FMT_SHORT: begin lo = -32768; hi = 32767; end
            default:             begin lo = -64'sd2147483648; hi = 64'sd2147483647; end
        endcase
    endfunction

    function automatic logic [63:0] width_bits(pfcs_pkg::fmt_t f);
        case (f)
            pfcs_pkg::FMT_SHORT:                      return 64'hFFFF;
            pfcs_pkg::FMT_LONG, pfcs_pkg::FMT_SINGLE: return 64'hFFFF_FFFF;
            pfcs_pkg::FMT_DOUBLE:                     return '1;
            default:                                  return 64'hFF;
        endcase
    endfunction

    function automatic void convert_pixel(pfcs_pkg::fmt_t sf, pfcs_pkg::fmt_t tf,
                                          logic [63:0] raw,
                                          output logic [63:0] pix, output logic clip);
        longint      v, lo, hi;
        logic [63:0] db;
        real         d;
        pix = '0;
        clip = 1'b0;
        if (sf == FMT_NONE || tf == FMT_NONE) return;
        if (sf == tf) begin
            pix = raw & width_bits(sf);
            return;
        end
        if (sf <= pfcs_pkg::FMT_LONG) begin
            case (sf)
                pfcs_pkg::FMT_SBYTE: v = longint'($signed(raw[7:0]));
                pfcs_pkg::FMT_SHORT: v = longint'($signed(raw[15:0]));
                pfcs_pkg::FMT_LONG:  v = longint'($signed(raw[31:0]));
                default:             v = longint'(raw[7:0]);
            endcase
            if (tf <= pfcs_pkg::FMT_LONG) begin
                int_range(tf, lo, hi);
                if (v < lo) begin v = lo; clip = 1'b1; end
                if (v > hi) begin v = hi; clip = 1'b1; end
                pix = 64'(v) & width_bits(tf);
            end else if (tf == pfcs_pkg::FMT_SINGLE)
                pix = {32'd0, narrow_double($realtobits(real'(v)))};
            else
                pix = $realtobits(real'(v));
            return;
        end
        db = (sf == pfcs_pkg::FMT_SINGLE) ? widen_single(raw[31:0]) : raw;
        if (db[62:52] == 11'h7FF && db[51:0] != 0) return;   // NaN
        if (tf <= pfcs_pkg::FMT_LONG) begin
            d = $bitstoreal(db);
            int_range(tf, lo, hi);
            if (d < real'(lo)) begin d = real'(lo); clip = 1'b1; end
            if (d > real'(hi)) begin d = real'(hi); clip = 1'b1; end
            v = (tf == pfcs_pkg::FMT_LONG) ? longint'($rtoi(d)) : round_even(d);
            pix = 64'(v) & width_bits(tf);
        end else if (tf == pfcs_pkg::FMT_DOUBLE)
            pix = db;
        else
            pix = {32'd0, narrow_double(db)};
    endfunction

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (want_pix_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // one pixel transaction; lowers valid only when a gap precedes it
    task automatic send_pixel(pfcs_pkg::fmt_t sf, pfcs_pkg::fmt_t tf, logic [63:0] raw,
                              int gap);
        logic [63:0] p;
        logic        c;
        if (sf != cur_sf || tf != cur_tf) begin
            s_valid <= 1'b0;
            drain();
            reg_write(ADDR_SRC, 32'(sf));
            reg_write(ADDR_DST, 32'(tf));
            cur_sf = sf;
            cur_tf = tf;
            gap = 1;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel_in <= raw;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        convert_pixel(sf, tf, raw, p, c);
        want_pix_q.push_back(p);
        want_clip_q.push_back(c);
    endtask

    function automatic logic [63:0] random_pixel(pfcs_pkg::fmt_t sf);
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return r;
            1: if (sf == pfcs_pkg::FMT_SINGLE)
                   return {r[63:32], r[31], 8'($urandom_range(120, 160)), r[22:0]};
               else
                   return {r[63], 11'($urandom_range(1016, 1056)), r[51:0]};
            2: return {r[63:32], r[31], 8'($urandom_range(110, 135)), r[22:20], 20'd0};
            default: return {r[63], 11'($urandom_range(1018, 1036)), r[51:45], 45'd0};
        endcase
    endfunction

    vec_t table_rows[] = '{
        '{pfcs_pkg::FMT_BIT,    pfcs_pkg::FMT_BIT,    64'hFFFF_FFFF_FFFF_FF05, 1, 64'h05, 0},
        '{pfcs_pkg::FMT_BIT,    pfcs_pkg::FMT_SBYTE,  64'h02,                  1, 64'h02, 0},
        '{pfcs_pkg::FMT_BIT,    pfcs_pkg::FMT_SBYTE,  64'hFF,                  1, 64'h7F, 1},
        '{pfcs_pkg::FMT_UBYTE,  pfcs_pkg::FMT_BIT,    64'hFF,                  1, 64'h01, 1},
        '{pfcs_pkg::FMT_UBYTE,  pfcs_pkg::FMT_BIT,    64'h00,                  1, 64'h00, 0},
        '{pfcs_pkg::FMT_SBYTE,  pfcs_pkg::FMT_UBYTE,  64'h80,                  1, 64'h00, 1},
        '{pfcs_pkg::FMT_SBYTE,  pfcs_pkg::FMT_SHORT,  64'h80,                  1, 64'hFF80, 0},
        '{pfcs_pkg::FMT_SHORT,  pfcs_pkg::FMT_SBYTE,  64'h7FFF,                1, 64'h7F, 1},
        '{pfcs_pkg::FMT_SHORT,  pfcs_pkg::FMT_SBYTE,  64'h8000,                1, 64'h80, 1},
        '{pfcs_pkg::FMT_LONG,   pfcs_pkg::FMT_SHORT,  64'h8000_0000,           1, 64'h8000, 1},
        '{pfcs_pkg::FMT_LONG,   pfcs_pkg::FMT_SINGLE, 64'h7FFF_FFFF,           0, 0, 0},
        '{pfcs_pkg::FMT_LONG,   pfcs_pkg::FMT_DOUBLE, 64'h8000_0000,
          1, 64'hC1E0_0000_0000_0000, 0},
        '{pfcs_pkg::FMT_SINGLE, pfcs_pkg::FMT_UBYTE,  64'h3FC0_0000,           0, 0, 0},
        '{pfcs_pkg::FMT_SINGLE, pfcs_pkg::FMT_UBYTE,  64'h4020_0000,           0, 0, 0},
        '{pfcs_pkg::FMT_SINGLE, pfcs_pkg::FMT_SBYTE,  64'h7FC0_0000,           1, 64'h00, 0},
        '{pfcs_pkg::FMT_SINGLE, pfcs_pkg::FMT_SBYTE,  64'hFF80_0000,           1, 64'h80, 1},
        '{pfcs_pkg::FMT_SINGLE, pfcs_pkg::FMT_LONG,   64'hCF80_0000,
          1, 64'h8000_0000, 1},
        '{pfcs_pkg::FMT_SINGLE, pfcs_pkg::FMT_LONG,   64'hBFE0_0000,
          1, 64'hFFFF_FFFF, 0},
        '{pfcs_pkg::FMT_SINGLE, pfcs_pkg::FMT_DOUBLE, 64'h0000_0001,           0, 0, 0},
        '{pfcs_pkg::FMT_SINGLE, pfcs_pkg::FMT_SINGLE, 64'hFFFF_FFFF_7FC0_0001,
          1, 64'h7FC0_0001, 0},
        '{pfcs_pkg::FMT_DOUBLE, pfcs_pkg::FMT_SINGLE, 64'h7E37_E43C_8800_759C,
          1, 64'h7F80_0000, 0},
        '{pfcs_pkg::FMT_DOUBLE, pfcs_pkg::FMT_SINGLE, 64'hFFEF_FFFF_FFFF_FFFF,
          1, 64'hFF80_0000, 0},
        '{pfcs_pkg::FMT_DOUBLE, pfcs_pkg::FMT_SINGLE, 64'h0000_0000_0000_0001, 0, 0, 0},
        '{pfcs_pkg::FMT_DOUBLE, pfcs_pkg::FMT_SHORT,  64'hBFE0_0000_0000_0000, 1, 64'h0, 0},
        '{FMT_NONE,             pfcs_pkg::FMT_UBYTE,  64'h05,                  1, 64'h0, 0},
        '{pfcs_pkg::FMT_UBYTE,  FMT_NONE,             64'h05,                  1, 64'h0, 0}
    };

    initial begin : stimulus
        pfcs_pkg::fmt_t sf, tf;
        int             n, gap;
        bit             burst;
        bit             held;
        logic [63:0]    p;
        logic           c;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (table_rows[i]) begin
            if (table_rows[i].known) begin
                convert_pixel(table_rows[i].sf, table_rows[i].tf, table_rows[i].pix, p, c);
                if (p !== table_rows[i].want_pix || c !== table_rows[i].want_clip) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row %0d: predictor gives %h/%0b, table %h/%0b", i, p, c,
                                 table_rows[i].want_pix, table_rows[i].want_clip);
                end
            end
            send_pixel(table_rows[i].sf, table_rows[i].tf, table_rows[i].pix,
                       $urandom_range(0, 3));
        end
        n = 0;
        burst = 0;
        held = 0;
        while (n < RANDOM_ITEMS) begin
            sf = ($urandom_range(0, 15) == 0) ? FMT_NONE
                                              : pfcs_pkg::fmt_t'($urandom_range(0, 6));
            tf = ($urandom_range(0, 15) == 0) ? FMT_NONE
                                              : pfcs_pkg::fmt_t'($urandom_range(0, 6));
            if ($urandom_range(0, 9) == 0) tf = sf;
            // backpressure phase: receiver stalls while sender keeps offering
            if (!held && n >= 100) begin
                long_hold = 1;
                held = 1;
            end
            repeat ($urandom_range(20, 50)) begin
                if ($urandom_range(0, 15) == 0) burst = !burst;
                gap = (burst || long_hold) ? 0 : $urandom_range(0, 17);
                send_pixel(sf, tf,
                           (sf >= pfcs_pkg::FMT_SINGLE) ? random_pixel(sf)
                                                        : {$urandom, $urandom},
                           gap);
                n++;
            end
        end
        s_valid <= 1'b0;
        drain();
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin : receiver
        int stall;
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                long_hold = 0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (want_pix_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: pixel %h clipped %0b",
                             m_pixel_out, m_clipped);
            end else begin
                if (m_pixel_out !== want_pix_q[0] || m_clipped !== want_clip_q[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: pixel %h clipped %0b, expected %h %0b",
                                 m_pixel_out, m_clipped, want_pix_q[0], want_clip_q[0]);
                end
                void'(want_pix_q.pop_front());
                void'(want_clip_q.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: errors");
            $finish;
        end
    end

endmodule

/* sim.f */
design/pfcs_pkg.sv
design/pfcs_unpack.sv
design/pfcs_norm.sv
design/pfcs_align.sv
design/pfcs_pack.sv
design/pixel_format_convert_saturate.sv
tb/testbench.sv
